[rtl/rrps_pkg.sv]
`timescale 1ns / 1ps

package rrps_pkg;

  localparam int SLOTS_DEF = 16;
  localparam int ID_W      = 16;
  localparam int TICK_W    = 16;
  localparam int QLEN_W    = 8;
  localparam int OUT_SLOT_W = 4;

  localparam logic [QLEN_W-1:0] QLEN_RST = 8'd2;

  // request opcodes
  localparam logic OP_CREATE = 1'b0;
  localparam logic OP_CYCLE  = 1'b1;

  // cycle events on the running process
  localparam logic [1:0] EV_NONE      = 2'd0;
  localparam logic [1:0] EV_TERMINATE = 2'd1;
  localparam logic [1:0] EV_SLEEP     = 2'd2;

  typedef enum logic [1:0] {
    ST_FINISHED = 2'd0,
    ST_READY    = 2'd1,
    ST_RUNNING  = 2'd2,
    ST_SLEEPING = 2'd3
  } slot_st_t;

  typedef struct packed {
    slot_st_t            status;
    logic [ID_W-1:0]     id;
    logic [TICK_W-1:0]   sleep_cnt;
  } row_t;

  localparam row_t ROW_RESET = '{status: ST_FINISHED, id: '0, sleep_cnt: '0};

endpackage

[rtl/rrps_ram.sv]
`timescale 1ns / 1ps

module rrps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/rrps_table.sv]
`timescale 1ns / 1ps

module rrps_table
  import rrps_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF,
  localparam int IDX_W = $clog2(SLOTS)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] rd_addr,
  output row_t             rd_row,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  row_t             wr_row
);

  logic [SLOTS-1:0] valid_r;
  logic [SLOTS-1:0] valid_nxt;
  logic [IDX_W-1:0] rd_addr_r;
  logic [$bits(row_t)-1:0] ram_q;

  rrps_ram #(
    .WIDTH($bits(row_t)),
    .DEPTH(SLOTS)
  ) u_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(wr_row),
    .raddr(rd_addr),
    .rdata(ram_q)
  );

  always_comb begin
    valid_nxt = valid_r;
    if (wr_en) begin
      valid_nxt[wr_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_r <= rd_addr;
  end

  // a row never written reads as its reset contents
  assign rd_row = valid_r[rd_addr_r] ? row_t'(ram_q) : ROW_RESET;

endmodule

[rtl/round_robin_process_scheduler.sv]
`timescale 1ns / 1ps
// one request at a time; the slot table is walked one row per cycle through one ram port
// create: scan, then write, then done; a cycle with no search: scan, quantum check, then done
// a cycle whose quantum expires or with nothing running searches again for a ready process
// a new request is taken only in idle, after the last result is loaded for output; in_ready idle only
// reset (rst_n low, synchronous) empties the table at once through per-row valid bits
module round_robin_process_scheduler
  import rrps_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [QLEN_W-1:0]     cfg_wr_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_op,
  input  logic [1:0]            in_event_req,
  input  logic [TICK_W-1:0]     in_sleep_ticks,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_create_ok,
  output logic [ID_W-1:0]       out_created_id,
  output logic                  out_running_valid,
  output logic [OUT_SLOT_W-1:0] out_running_slot,
  output logic [ID_W-1:0]       out_running_id,
  output logic                  out_switched,
  output logic                  out_any_active
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_CR_SCAN  = 8'b0000_0010,
    S_CR_WRITE = 8'b0000_0100,
    S_CY_SCAN  = 8'b0000_1000,
    S_CY_QUANT = 8'b0001_0000,
    S_SCH_SCAN = 8'b0010_0000,
    S_SCH_OLD  = 8'b0100_0000,
    S_DONE     = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [QLEN_W-1:0] qlen_r, qlen_nxt;
  logic [IDX_W-1:0]  cur_r, cur_nxt;
  logic              cur_valid_r, cur_valid_nxt;
  logic [ID_W-1:0]   cur_id_r, cur_id_nxt;
  logic [QLEN_W-1:0] q_r, q_nxt;
  logic [ID_W-1:0]   last_id_r, last_id_nxt;

  logic              op_r, op_nxt;
  logic              ev_app_r, ev_app_nxt;
  logic              ev_term_r, ev_term_nxt;
  logic [TICK_W-1:0] ticks_r, ticks_nxt;
  logic [IDX_W-1:0]  ev_slot_r, ev_slot_nxt;

  logic [IDX_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  iss_cnt_r, iss_cnt_nxt;
  logic              pend_r, pend_nxt;
  logic [IDX_W-1:0]  proc_addr_r, proc_addr_nxt;
  logic              proc_last_r, proc_last_nxt;

  logic              p0_found_r, p0_found_nxt;
  logic [IDX_W-1:0]  p0_r, p0_nxt;
  logic              p1_found_r, p1_found_nxt;
  logic [IDX_W-1:0]  p1_r, p1_nxt;
  logic              live_r, live_nxt;
  logic              ok_r, ok_nxt;
  logic              sw_r, sw_nxt;
  logic [IDX_W-1:0]  nsl_r, nsl_nxt;
  logic [ID_W-1:0]   nid_r, nid_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic                  out_ok_r, out_ok_nxt;
  logic [ID_W-1:0]       out_cid_r, out_cid_nxt;
  logic                  out_rv_r, out_rv_nxt;
  logic [OUT_SLOT_W-1:0] out_rs_r, out_rs_nxt;
  logic [ID_W-1:0]       out_rid_r, out_rid_nxt;
  logic                  out_sw_r, out_sw_nxt;
  logic                  out_act_r, out_act_nxt;

  logic             tbl_wr_en;
  logic [IDX_W-1:0] tbl_wr_addr;
  row_t             tbl_wr_row;
  row_t             tbl_rd_row;
  row_t             pre_row;

  logic             in_acc;
  logic             scanning;
  logic             issue;
  logic [TICK_W-1:0] dec_cnt;
  logic [ID_W-1:0]  new_id;
  logic [QLEN_W-1:0] q_inc;

  rrps_table #(
    .SLOTS(SLOTS)
  ) u_table (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_addr(rd_ptr_r),
    .rd_row (tbl_rd_row),
    .wr_en  (tbl_wr_en),
    .wr_addr(tbl_wr_addr),
    .wr_row (tbl_wr_row)
  );

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign scanning = (state_r == S_CR_SCAN) || (state_r == S_CY_SCAN) ||
                    (state_r == S_SCH_SCAN);
  assign issue    = scanning && (iss_cnt_r != CNT_W'(SLOTS));
  assign q_inc    = q_r + QLEN_W'(1);
  assign new_id   = (last_id_r == {ID_W{1'b1}}) ? ID_W'(1) : last_id_r + ID_W'(1);

  // row as it stands once the event on the running process is applied
  always_comb begin
    pre_row = tbl_rd_row;
    if (ev_app_r && (proc_addr_r == ev_slot_r)) begin
      if (ev_term_r) begin
        pre_row.status = ST_FINISHED;
      end else begin
        pre_row.status    = ST_SLEEPING;
        pre_row.sleep_cnt = ticks_r;
      end
    end
    dec_cnt = (pre_row.sleep_cnt == '0) ? '0 : pre_row.sleep_cnt - TICK_W'(1);
  end

  always_comb begin
    state_nxt     = state_r;
    qlen_nxt      = cfg_wr_en ? cfg_wr_data : qlen_r;
    cur_nxt       = cur_r;
    cur_valid_nxt = cur_valid_r;
    cur_id_nxt    = cur_id_r;
    q_nxt         = q_r;
    last_id_nxt   = last_id_r;
    op_nxt        = op_r;
    ev_app_nxt    = ev_app_r;
    ev_term_nxt   = ev_term_r;
    ticks_nxt     = ticks_r;
    ev_slot_nxt   = ev_slot_r;
    rd_ptr_nxt    = rd_ptr_r;
    iss_cnt_nxt   = iss_cnt_r;
    pend_nxt      = issue;
    proc_addr_nxt = rd_ptr_r;
    proc_last_nxt = (iss_cnt_r == CNT_W'(SLOTS - 1));
    p0_found_nxt  = p0_found_r;
    p0_nxt        = p0_r;
    p1_found_nxt  = p1_found_r;
    p1_nxt        = p1_r;
    live_nxt      = live_r;
    ok_nxt        = ok_r;
    sw_nxt        = sw_r;
    nsl_nxt       = nsl_r;
    nid_nxt       = nid_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_ok_nxt    = out_ok_r;
    out_cid_nxt   = out_cid_r;
    out_rv_nxt    = out_rv_r;
    out_rs_nxt    = out_rs_r;
    out_rid_nxt   = out_rid_r;
    out_sw_nxt    = out_sw_r;
    out_act_nxt   = out_act_r;
    tbl_wr_en     = 1'b0;
    tbl_wr_addr   = proc_addr_r;
    tbl_wr_row    = pre_row;

    if (issue) begin
      rd_ptr_nxt  = (rd_ptr_r == IDX_W'(SLOTS - 1)) ? '0 : rd_ptr_r + IDX_W'(1);
      iss_cnt_nxt = iss_cnt_r + CNT_W'(1);
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt       = in_op;
          ev_app_nxt   = (in_op == OP_CYCLE) && cur_valid_r &&
                         ((in_event_req == EV_TERMINATE) || (in_event_req == EV_SLEEP));
          ev_term_nxt  = (in_event_req == EV_TERMINATE);
          ticks_nxt    = in_sleep_ticks;
          ev_slot_nxt  = cur_r;
          ok_nxt       = 1'b0;
          sw_nxt       = 1'b0;
          live_nxt     = 1'b0;
          p0_found_nxt = 1'b0;
          p1_found_nxt = 1'b0;
          rd_ptr_nxt   = '0;
          iss_cnt_nxt  = '0;
          if (ev_app_nxt) begin
            cur_valid_nxt = 1'b0;
          end
          state_nxt = (in_op == OP_CYCLE) ? S_CY_SCAN : S_CR_SCAN;
        end
      end

      S_CR_SCAN: begin
        if (pend_r) begin
          if (!p0_found_r && (tbl_rd_row.id == '0)) begin
            p0_found_nxt = 1'b1;
            p0_nxt       = proc_addr_r;
          end
          if (!p1_found_r && (tbl_rd_row.status == ST_FINISHED)) begin
            p1_found_nxt = 1'b1;
            p1_nxt       = proc_addr_r;
          end
          if ((tbl_rd_row.status != ST_FINISHED) && (tbl_rd_row.id != '0)) begin
            live_nxt = 1'b1;
          end
          if (proc_last_r) begin
            state_nxt = S_CR_WRITE;
          end
        end
      end

      S_CR_WRITE: begin
        if (p0_found_r || p1_found_r) begin
          tbl_wr_en   = 1'b1;
          tbl_wr_addr = p0_found_r ? p0_r : p1_r;
          tbl_wr_row  = '{status: ST_READY, id: new_id, sleep_cnt: '0};
          last_id_nxt = new_id;
          ok_nxt      = 1'b1;
        end
        state_nxt = S_DONE;
      end

      S_CY_SCAN: begin
        if (pend_r) begin
          tbl_wr_en = 1'b1;
          // dispatch after an event sees the table before this tick's wakeups
          if (ev_app_r && !cur_valid_r && (pre_row.status == ST_READY) &&
              (pre_row.id != '0)) begin
            tbl_wr_row.status = ST_RUNNING;
            cur_nxt           = proc_addr_r;
            cur_valid_nxt     = 1'b1;
            cur_id_nxt        = pre_row.id;
            q_nxt             = '0;
            sw_nxt            = 1'b1;
          end else if (pre_row.status == ST_SLEEPING) begin
            tbl_wr_row.sleep_cnt = dec_cnt;
            if (dec_cnt == '0) begin
              tbl_wr_row.status = ST_READY;
            end
          end
          if ((tbl_wr_row.status != ST_FINISHED) && (tbl_wr_row.id != '0)) begin
            live_nxt = 1'b1;
          end
          if (proc_last_r) begin
            state_nxt = S_CY_QUANT;
          end
        end
      end

      S_CY_QUANT: begin
        rd_ptr_nxt  = (cur_valid_r && (cur_r != IDX_W'(SLOTS - 1))) ?
                      cur_r + IDX_W'(1) : '0;
        iss_cnt_nxt = '0;
        if (cur_valid_r) begin
          if (q_inc >= qlen_r) begin
            q_nxt     = '0;
            state_nxt = S_SCH_SCAN;
          end else begin
            q_nxt     = q_inc;
            state_nxt = S_DONE;
          end
        end else begin
          state_nxt = S_SCH_SCAN;
        end
      end

      S_SCH_SCAN: begin
        if (pend_r) begin
          if ((tbl_rd_row.status == ST_READY) && (tbl_rd_row.id != '0)) begin
            tbl_wr_en         = 1'b1;
            tbl_wr_row        = tbl_rd_row;
            tbl_wr_row.status = ST_RUNNING;
            nsl_nxt           = proc_addr_r;
            nid_nxt           = tbl_rd_row.id;
            state_nxt         = S_SCH_OLD;
          end else if (proc_last_r) begin
            if (cur_valid_r) begin
              q_nxt = '0;
            end
            state_nxt = S_DONE;
          end
        end
      end

      S_SCH_OLD: begin
        // the preempted process goes back to ready
        if (cur_valid_r) begin
          tbl_wr_en   = 1'b1;
          tbl_wr_addr = cur_r;
          tbl_wr_row  = '{status: ST_READY, id: cur_id_r, sleep_cnt: '0};
        end
        cur_nxt       = nsl_r;
        cur_id_nxt    = nid_r;
        cur_valid_nxt = 1'b1;
        q_nxt         = '0;
        sw_nxt        = 1'b1;
        state_nxt     = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = ok_r;
          out_cid_nxt   = ok_r ? last_id_r : '0;
          out_rv_nxt    = cur_valid_r;
          out_rs_nxt    = cur_valid_r ? OUT_SLOT_W'(cur_r) : '0;
          out_rid_nxt   = cur_valid_r ? cur_id_r : '0;
          out_sw_nxt    = sw_r;
          out_act_nxt   = live_r || ok_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      qlen_r      <= QLEN_RST;
      cur_r       <= '0;
      cur_valid_r <= 1'b0;
      q_r         <= '0;
      last_id_r   <= '0;
      iss_cnt_r   <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      qlen_r      <= qlen_nxt;
      cur_r       <= cur_nxt;
      cur_valid_r <= cur_valid_nxt;
      q_r         <= q_nxt;
      last_id_r   <= last_id_nxt;
      iss_cnt_r   <= iss_cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_id_r    <= cur_id_nxt;
    op_r        <= op_nxt;
    ev_app_r    <= ev_app_nxt;
    ev_term_r   <= ev_term_nxt;
    ticks_r     <= ticks_nxt;
    ev_slot_r   <= ev_slot_nxt;
    rd_ptr_r    <= rd_ptr_nxt;
    proc_addr_r <= proc_addr_nxt;
    proc_last_r <= proc_last_nxt;
    p0_found_r  <= p0_found_nxt;
    p0_r        <= p0_nxt;
    p1_found_r  <= p1_found_nxt;
    p1_r        <= p1_nxt;
    live_r      <= live_nxt;
    ok_r        <= ok_nxt;
    sw_r        <= sw_nxt;
    nsl_r       <= nsl_nxt;
    nid_r       <= nid_nxt;
    out_ok_r    <= out_ok_nxt;
    out_cid_r   <= out_cid_nxt;
    out_rv_r    <= out_rv_nxt;
    out_rs_r    <= out_rs_nxt;
    out_rid_r   <= out_rid_nxt;
    out_sw_r    <= out_sw_nxt;
    out_act_r   <= out_act_nxt;
  end

  // op_r records the request kind for the current item; create never switches
  assign out_valid         = out_valid_r;
  assign out_create_ok     = out_ok_r && (op_r == OP_CREATE || !out_valid_r || out_ok_r);
  assign out_created_id    = out_cid_r;
  assign out_running_valid = out_rv_r;
  assign out_running_slot  = out_rs_r;
  assign out_running_id    = out_rid_r;
  assign out_switched      = out_sw_r;
  assign out_any_active    = out_act_r;

endmodule

[tb/sv/round_robin_process_scheduler_tb.sv]
`timescale 1ns / 1ps

module round_robin_process_scheduler_tb;
  import rrps_pkg::*;

  localparam int SLOTS = SLOTS_DEF;
  localparam logic [1:0] EV_UNUSED = 2'd3;
  localparam int N_PHASES = 7;
  localparam int PHASE_REQUESTS = 260;
  localparam int SETTLE_CYCLES = 2 * SLOTS + 8;
  localparam int STALL_LIMIT = 5000;

  typedef struct packed {
    logic                  create_ok;
    logic [ID_W-1:0]       created_id;
    logic                  running_valid;
    logic [OUT_SLOT_W-1:0] running_slot;
    logic [ID_W-1:0]       running_id;
    logic                  switched;
    logic                  any_active;
  } sched_out_t;

  typedef struct packed {
    logic              op;
    logic [1:0]        ev;
    logic [TICK_W-1:0] ticks;
    logic              typed;
    sched_out_t        want;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [QLEN_W-1:0]     cfg_wr_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_op = OP_CREATE;
  logic [1:0]            in_event_req = EV_NONE;
  logic [TICK_W-1:0]     in_sleep_ticks = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_create_ok;
  logic [ID_W-1:0]       out_created_id;
  logic                  out_running_valid;
  logic [OUT_SLOT_W-1:0] out_running_slot;
  logic [ID_W-1:0]       out_running_id;
  logic                  out_switched;
  logic                  out_any_active;

  round_robin_process_scheduler #(.SLOTS(SLOTS)) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_event_req     (in_event_req),
    .in_sleep_ticks   (in_sleep_ticks),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_create_ok    (out_create_ok),
    .out_created_id   (out_created_id),
    .out_running_valid(out_running_valid),
    .out_running_slot (out_running_slot),
    .out_running_id   (out_running_id),
    .out_switched     (out_switched),
    .out_any_active   (out_any_active)
  );

  always #5 clk = ~clk;

  // shadow process table
  slot_st_t          tbl_status [SLOTS];
  logic [ID_W-1:0]   tbl_id     [SLOTS];
  logic [TICK_W-1:0] tbl_sleep  [SLOTS];
  int                cur_slot;
  bit                cur_valid;
  logic [QLEN_W-1:0] q_count;
  logic [QLEN_W-1:0] q_len;
  logic [ID_W-1:0]   last_id;

  sched_out_t predicted_outcomes [$];
  dir_row_t   dir_rows [$];

  int errors = 0;
  int n_checked = 0;
  int n_creates = 0;
  int n_cycles = 0;
  int n_full = 0;
  int n_dispatch = 0;
  int n_sleeps = 0;
  int n_terms = 0;
  int idle_cycles = 0;

  function automatic int next_ready_slot();
    int start;
    int k;
    start = cur_valid ? (cur_slot + 1) % SLOTS : 0;
    for (int i = 0; i < SLOTS; i++) begin
      k = (start + i) % SLOTS;
      if (tbl_status[k] == ST_READY && tbl_id[k] != '0) return k;
    end
    return -1;
  endfunction

  function automatic bit dispatch_next();
    int nxt;
    nxt = next_ready_slot();
    if (nxt < 0) begin
      if (cur_valid) q_count = '0;
      return 1'b0;
    end
    if (cur_valid && tbl_status[cur_slot] == ST_RUNNING) tbl_status[cur_slot] = ST_READY;
    cur_slot = nxt;
    cur_valid = 1'b1;
    q_count = '0;
    tbl_status[nxt] = ST_RUNNING;
    return 1'b1;
  endfunction

  function automatic sched_out_t apply_request(logic op, logic [1:0] ev,
                                               logic [TICK_W-1:0] ticks);
    sched_out_t r;
    int pick;
    bit sw;
    r = '0;
    sw = 1'b0;
    if (op == OP_CREATE) begin
      pick = -1;
      // never-used slots first, then finished ones
      for (int i = 0; i < SLOTS; i++)
        if (pick < 0 && tbl_id[i] == '0) pick = i;
      for (int i = 0; i < SLOTS; i++)
        if (pick < 0 && tbl_status[i] == ST_FINISHED) pick = i;
      if (pick >= 0) begin
        last_id = last_id + 1'b1;
        if (last_id == '0) last_id = ID_W'(1);
        tbl_id[pick] = last_id;
        tbl_status[pick] = ST_READY;
        tbl_sleep[pick] = '0;
        r.create_ok = 1'b1;
        r.created_id = last_id;
      end
    end else begin
      if (cur_valid && (ev == EV_TERMINATE || ev == EV_SLEEP)) begin
        if (ev == EV_TERMINATE) begin
          tbl_status[cur_slot] = ST_FINISHED;
        end else begin
          tbl_status[cur_slot] = ST_SLEEPING;
          tbl_sleep[cur_slot] = ticks;
        end
        cur_valid = 1'b0;
        if (dispatch_next()) sw = 1'b1;
      end
      for (int i = 0; i < SLOTS; i++) begin
        if (tbl_status[i] == ST_SLEEPING) begin
          if (tbl_sleep[i] != '0) tbl_sleep[i] = tbl_sleep[i] - 1'b1;
          if (tbl_sleep[i] == '0) tbl_status[i] = ST_READY;
        end
      end
      if (cur_valid) begin
        q_count = q_count + 1'b1;
        if (q_count >= q_len) begin
          q_count = '0;
          if (dispatch_next()) sw = 1'b1;
        end
      end else if (dispatch_next()) begin
        sw = 1'b1;
      end
    end
    if (cur_valid) begin
      r.running_valid = 1'b1;
      r.running_slot = OUT_SLOT_W'(cur_slot);
      r.running_id = tbl_id[cur_slot];
    end
    r.switched = sw;
    for (int i = 0; i < SLOTS; i++)
      if (tbl_status[i] != ST_FINISHED && tbl_id[i] != '0) r.any_active = 1'b1;
    return r;
  endfunction

  function automatic sched_out_t outcome(logic ok, logic [ID_W-1:0] cid, logic rv,
                                         logic [OUT_SLOT_W-1:0] slot, logic [ID_W-1:0] rid,
                                         logic sw, logic act);
    sched_out_t r;
    r.create_ok = ok;
    r.created_id = cid;
    r.running_valid = rv;
    r.running_slot = slot;
    r.running_id = rid;
    r.switched = sw;
    r.any_active = act;
    return r;
  endfunction

  task automatic add_row(logic op, logic [1:0] ev, logic [TICK_W-1:0] ticks,
                         logic typed, sched_out_t want);
    dir_row_t row;
    row.op = op;
    row.ev = ev;
    row.ticks = ticks;
    row.typed = typed;
    row.want = want;
    dir_rows.push_back(row);
  endtask

  // present one request, hold it until taken, then drop valid
  task automatic send_request(logic op, logic [1:0] ev, logic [TICK_W-1:0] ticks,
                              logic typed, sched_out_t want);
    sched_out_t pred;
    @(negedge clk);
    in_valid <= 1'b1;
    in_op <= op;
    in_event_req <= ev;
    in_sleep_ticks <= ticks;
    do @(posedge clk); while (!in_ready);
    pred = apply_request(op, ev, ticks);
    predicted_outcomes.push_back(typed ? want : pred);
    if (op == OP_CREATE) begin
      n_creates++;
      if (!pred.create_ok) n_full++;
    end else begin
      n_cycles++;
      if (ev == EV_SLEEP) n_sleeps++;
      if (ev == EV_TERMINATE) n_terms++;
    end
    if (pred.switched) n_dispatch++;
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic drain_results();
    while (predicted_outcomes.size() != 0) @(posedge clk);
  endtask

  task automatic write_quantum(logic [QLEN_W-1:0] value);
    drain_results();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    q_len = value;
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // receiver: ready pattern switches among modes of random length
  int       rx_mode = 0;
  int       rx_left = 0;
  logic [7:0] rx_pat = 8'hA5;

  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(0, 3);
      rx_left <= $urandom_range(20, 200);
      rx_pat <= 8'($urandom);
    end else begin
      rx_left <= rx_left - 1;
      rx_pat <= {rx_pat[6:0], rx_pat[7]};
    end
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 9) < 6);
      2: out_ready <= rx_pat[0];
      default: out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk) begin : result_check
    sched_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (predicted_outcomes.size() == 0) begin
        errors++;
        $display("%0t: result with no request outstanding", $time);
      end else begin
        want = predicted_outcomes.pop_front();
        n_checked++;
        check_field("create_ok", want.create_ok, out_create_ok);
        check_field("created_id", want.created_id, out_created_id);
        check_field("running_valid", want.running_valid, out_running_valid);
        check_field("running_slot", want.running_slot, out_running_slot);
        check_field("running_id", want.running_id, out_running_id);
        check_field("switched", want.switched, out_switched);
        check_field("any_active", want.any_active, out_any_active);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles, %0d results outstanding", $time,
                 STALL_LIMIT, predicted_outcomes.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    int burst_left;
    int gap;
    int sel;
    int create_pct;
    logic [QLEN_W-1:0] qv;
    logic op;
    logic [1:0] ev;
    logic [TICK_W-1:0] ticks;

    for (int i = 0; i < SLOTS; i++) begin
      tbl_status[i] = ST_FINISHED;
      tbl_id[i] = '0;
      tbl_sleep[i] = '0;
    end
    cur_slot = 0;
    cur_valid = 1'b0;
    q_count = '0;
    q_len = QLEN_RST;
    last_id = '0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty table, events with nothing running, first create and dispatch
    add_row(OP_CYCLE, EV_NONE, 16'h0000, 1'b1,
            outcome(1'b0, 16'd0, 1'b0, 4'd0, 16'd0, 1'b0, 1'b0));
    add_row(OP_CYCLE, EV_TERMINATE, 16'hFFFF, 1'b1,
            outcome(1'b0, 16'd0, 1'b0, 4'd0, 16'd0, 1'b0, 1'b0));
    add_row(OP_CREATE, EV_NONE, 16'h0000, 1'b1,
            outcome(1'b1, 16'd1, 1'b0, 4'd0, 16'd0, 1'b0, 1'b1));
    add_row(OP_CYCLE, EV_NONE, 16'h0000, 1'b1,
            outcome(1'b0, 16'd0, 1'b1, 4'd0, 16'd1, 1'b1, 1'b1));
    for (int i = 1; i < SLOTS; i++)
      add_row(OP_CREATE, EV_UNUSED, 16'hFFFF, 1'b0, '0);
    // table full
    add_row(OP_CREATE, EV_SLEEP, 16'h0001, 1'b1,
            outcome(1'b0, 16'd0, 1'b1, 4'd0, 16'd1, 1'b0, 1'b1));
    add_row(OP_CYCLE, EV_UNUSED, 16'hFFFF, 1'b0, '0);
    add_row(OP_CYCLE, EV_NONE, 16'h0000, 1'b0, '0);
    // zero and one tick sleeps wake in the same cycle
    add_row(OP_CYCLE, EV_SLEEP, 16'h0000, 1'b0, '0);
    add_row(OP_CYCLE, EV_SLEEP, 16'h0001, 1'b0, '0);
    add_row(OP_CYCLE, EV_SLEEP, 16'hFFFF, 1'b0, '0);
    add_row(OP_CYCLE, EV_TERMINATE, 16'h0000, 1'b0, '0);
    // reuse of a finished slot
    add_row(OP_CREATE, EV_NONE, 16'h0000, 1'b0, '0);

    write_quantum(QLEN_RST);
    foreach (dir_rows[i])
      send_request(dir_rows[i].op, dir_rows[i].ev, dir_rows[i].ticks, dir_rows[i].typed,
                   dir_rows[i].want);

    // long quantum comes before the short one so the count overshoots it
    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: qv = 8'd255;
        1: qv = 8'd1;
        2: qv = 8'd0;
        3: qv = QLEN_W'($urandom_range(3, 16));
        4: qv = 8'd128;
        5: qv = QLEN_W'($urandom_range(1, 255));
        default: qv = QLEN_RST;
      endcase
      write_quantum(qv);
      create_pct = $urandom_range(15, 45);
      burst_left = 0;
      for (int n = 0; n < PHASE_REQUESTS; n++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 16);
          sel = $urandom_range(0, 3);
          gap = (sel == 0) ? 0 : (sel == 3) ? $urandom_range(10, 50) : $urandom_range(1, 10);
          repeat (gap) @(negedge clk);
        end
        burst_left--;
        if ($urandom_range(0, 63) == 0) drain_results();
        op = ($urandom_range(0, 99) < create_pct) ? OP_CREATE : OP_CYCLE;
        sel = $urandom_range(0, 99);
        ev = (sel < 45) ? EV_NONE : (sel < 65) ? EV_TERMINATE : (sel < 92) ? EV_SLEEP
           : EV_UNUSED;
        sel = $urandom_range(0, 99);
        ticks = (sel < 85) ? TICK_W'($urandom_range(0, 24))
              : (sel < 99) ? TICK_W'($urandom_range(25, 400))
              : TICK_W'($urandom_range(0, 65535));
        send_request(op, ev, ticks, 1'b0, '0);
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (predicted_outcomes.size() != 0) begin
      errors += predicted_outcomes.size();
      $display("%0t: %0d results never arrived", $time, predicted_outcomes.size());
    end

    $display("covered %0d creates (%0d on a full table), %0d ticks (%0d sleeps, %0d kills)",
             n_creates, n_full, n_cycles, n_sleeps, n_terms);
    $display("%0d dispatches, %0d quantum settings, last id %0d, %0d checked, %0d errors",
             n_dispatch, N_PHASES + 1, last_id, n_checked, errors);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
